@@ hdl/i2cm_pkg.sv @@
// Package for the I2C register-transfer master.
// Holds the word types of both channels, the sequencer codes and reset constants.
// No dependencies.
package i2cm_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_BYTE  = 2'd3
  } req_e;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RECOVER  = 4'd1,
    PH_START    = 4'd2,
    PH_TXBIT    = 4'd3,
    PH_TXREL    = 4'd4,
    PH_ACK_LEAD = 4'd5,
    PH_ACK_HIGH = 4'd6,
    PH_ACK_TAIL = 4'd7,
    PH_RXBIT    = 4'd8,
    PH_WAITB    = 4'd9,
    PH_STOP     = 4'd10
  } phase_e;

  // Which byte of the transfer is on the bus
  typedef enum logic [2:0] {
    ST_ADDR_W = 3'd0,
    ST_REG    = 3'd1,
    ST_ADDR_R = 3'd2,
    ST_DATA_W = 3'd3,
    ST_DATA_R = 3'd4
  } stage_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_RECOVERY_LIMIT = 1'b0,
    CFG_ACK_HIGH_TICKS = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] RESET_RECOVERY = 16'd500;
  localparam logic [7:0]  RESET_ACK_HIGH = 8'd10;
  localparam logic [7:0]  MSB_MASK       = 8'h80;
  localparam logic        LSB_BIT        = 1'b1;

  // Input word
  typedef struct packed {
    logic [1:0] req_type;
    logic       sda_in;
    logic [6:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
  } i2cm_req_t;

  // Result word
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       need_byte;
    logic       read_valid;
    logic [7:0] read_data;
    logic       last_byte;
    logic       done_res;
    logic       nack_error;
  } i2cm_res_t;

endpackage

@@ hdl/i2cm_seq.sv @@
// Bus sequencer of the I2C register-transfer master: state registers and one
// step of next-state logic per accepted word. Depends on i2cm_pkg.
module i2cm_seq import i2cm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  i2cm_req_t   req_i,
  input  logic [15:0] recovery_limit_i,
  input  logic [7:0]  ack_high_ticks_i,
  output i2cm_res_t   res_o
);

  phase_e      phase_q, phase_d;
  stage_e      stage_q, stage_d;
  logic [7:0]  tick_q, tick_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  left_q, left_d;
  logic [6:0]  target_q, target_d;
  logic [7:0]  regaddr_q, regaddr_d;
  logic        is_read_q, is_read_d;
  logic [15:0] rec_q, rec_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        failed_q, failed_d;

  logic        rv, lb, dn, er;
  logic [7:0]  rd;
  logic [3:0]  bit_inc;
  logic [8:0]  tick_inc;
  logic [7:0]  hold;
  logic [7:0]  rx_shift;
  logic [7:0]  left_dec;

  assign bit_inc  = bit_q + 4'd1;
  assign tick_inc = {1'b0, tick_q} + 9'd1;
  assign hold     = (ack_high_ticks_i == 8'd0) ? 8'd1 : ack_high_ticks_i;
  assign rx_shift = {shift_q[6:0], req_i.sda_in};
  assign left_dec = left_q - 8'd1;

  // Advance the sequence by one word
  always_comb begin
    phase_d   = phase_q;
    stage_d   = stage_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    left_d    = left_q;
    target_d  = target_q;
    regaddr_d = regaddr_q;
    is_read_d = is_read_q;
    rec_d     = rec_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    failed_d  = failed_q;
    rv = 1'b0;
    rd = 8'd0;
    lb = 1'b0;
    dn = 1'b0;
    er = 1'b0;

    case (req_i.req_type)
      REQ_WRITE, REQ_READ: begin
        // Latch a new transfer, ignored while busy
        if (phase_q == PH_IDLE) begin
          target_d  = req_i.slave_addr;
          regaddr_d = req_i.reg_addr;
          left_d    = req_i.byte_count;
          is_read_d = (req_i.req_type == REQ_READ);
          stage_d   = ST_ADDR_W;
          failed_d  = 1'b0;
          bit_d     = 4'd0;
          phase_d   = PH_RECOVER;
          tick_d    = 8'd0;
          rec_d     = 16'd0;
        end
      end
      REQ_BYTE: begin
        if (phase_q == PH_WAITB) begin
          shift_d = req_i.write_byte;
          left_d  = left_dec;
          bit_d   = 4'd0;
          phase_d = PH_TXBIT;
          tick_d  = 8'd0;
        end
      end
      default: begin
        case (phase_q)
          PH_RECOVER: begin
            // Pulse SCL while SDA is held low, up to the limit
            if (tick_q == 8'd0) begin
              scl_d  = 1'b0;
              tick_d = 8'd1;
              if (!req_i.sda_in &&
                  ({1'b0, rec_q} + 17'd1 < {1'b0, recovery_limit_i})) begin
                rec_d = rec_q + 16'd1;
              end else begin
                phase_d = PH_START;
              end
            end else begin
              scl_d  = 1'b1;
              tick_d = 8'd0;
            end
          end
          PH_START: begin
            if (tick_q == 8'd1) begin
              sda_d  = 1'b1;
              tick_d = 8'd2;
            end else if (tick_q == 8'd2) begin
              scl_d  = 1'b1;
              tick_d = 8'd3;
            end else if (tick_q == 8'd3) begin
              sda_d  = 1'b0;
              tick_d = 8'd4;
            end else begin
              scl_d   = 1'b0;
              shift_d = {target_q, (stage_q == ST_ADDR_R) ? LSB_BIT : 1'b0};
              bit_d   = 4'd0;
              phase_d = PH_TXBIT;
              tick_d  = 8'd0;
            end
          end
          PH_TXBIT: begin
            if (tick_q == 8'd0) begin
              scl_d  = 1'b0;
              tick_d = 8'd1;
            end else if (tick_q == 8'd1) begin
              sda_d   = |(shift_q & MSB_MASK);
              shift_d = {shift_q[6:0], 1'b0};
              tick_d  = 8'd2;
            end else begin
              scl_d  = 1'b1;
              bit_d  = bit_inc;
              tick_d = 8'd0;
              if (bit_inc >= 4'd8) begin
                bit_d   = 4'd0;
                phase_d = PH_TXREL;
              end
            end
          end
          PH_TXREL: begin
            if (tick_q == 8'd0) begin
              scl_d  = 1'b0;
              tick_d = 8'd1;
            end else begin
              sda_d   = 1'b1;
              phase_d = PH_ACK_LEAD;
              tick_d  = 8'd0;
            end
          end
          PH_ACK_LEAD: begin
            if (tick_q == 8'd0) begin
              scl_d  = 1'b0;
              tick_d = 8'd1;
            end else begin
              // Master ACKs read bytes and NACKs the last; releases otherwise
              sda_d   = (stage_q == ST_DATA_R) ? (left_q == 8'd0) : 1'b1;
              phase_d = PH_ACK_HIGH;
              tick_d  = 8'd0;
            end
          end
          PH_ACK_HIGH: begin
            scl_d  = 1'b1;
            tick_d = tick_inc[7:0];
            if (tick_inc >= {1'b0, hold}) begin
              phase_d = PH_ACK_TAIL;
              tick_d  = 8'd0;
            end
          end
          PH_ACK_TAIL: begin
            if (tick_q == 8'd0) begin
              // Sample the slave's acknowledge
              if (stage_q != ST_DATA_R && req_i.sda_in) failed_d = 1'b1;
              scl_d  = 1'b0;
              tick_d = 8'd1;
            end else begin
              sda_d  = 1'b1;
              tick_d = 8'd0;
              if (failed_q) begin
                phase_d = PH_STOP;
              end else begin
                case (stage_q)
                  ST_ADDR_W: begin
                    stage_d = ST_REG;
                    shift_d = regaddr_q;
                    bit_d   = 4'd0;
                    phase_d = PH_TXBIT;
                  end
                  ST_REG: begin
                    if (is_read_q) begin
                      stage_d = ST_ADDR_R;
                      phase_d = PH_RECOVER;
                      rec_d   = 16'd0;
                    end else begin
                      stage_d = ST_DATA_W;
                      phase_d = (left_q != 8'd0) ? PH_WAITB : PH_STOP;
                    end
                  end
                  ST_DATA_W: begin
                    phase_d = (left_q != 8'd0) ? PH_WAITB : PH_STOP;
                  end
                  default: begin
                    if (left_q != 8'd0) begin
                      stage_d = ST_DATA_R;
                      bit_d   = 4'd0;
                      shift_d = 8'd0;
                      phase_d = PH_RXBIT;
                    end else begin
                      phase_d = PH_STOP;
                    end
                  end
                endcase
              end
            end
          end
          PH_RXBIT: begin
            if (tick_q == 8'd0) begin
              scl_d  = 1'b1;
              tick_d = 8'd1;
            end else begin
              // Shift in one bit, MSB first
              shift_d = rx_shift;
              scl_d   = 1'b0;
              bit_d   = bit_inc;
              tick_d  = 8'd0;
              if (bit_inc >= 4'd8) begin
                bit_d   = 4'd0;
                left_d  = left_dec;
                rv      = 1'b1;
                rd      = rx_shift;
                lb      = (left_dec == 8'd0);
                phase_d = PH_ACK_LEAD;
              end
            end
          end
          PH_STOP: begin
            if (tick_q == 8'd0) begin
              scl_d  = 1'b0;
              tick_d = 8'd1;
            end else if (tick_q == 8'd1) begin
              sda_d  = 1'b0;
              tick_d = 8'd2;
            end else if (tick_q == 8'd2) begin
              scl_d  = 1'b1;
              tick_d = 8'd3;
            end else begin
              sda_d    = 1'b1;
              dn       = 1'b1;
              er       = failed_q;
              failed_d = 1'b0;
              phase_d  = PH_IDLE;
              tick_d   = 8'd0;
            end
          end
          default: begin
            // Idle or waiting for a byte: hold the lines
          end
        endcase
      end
    endcase
  end

  // Assemble the result word
  always_comb begin
    res_o.scl_out    = scl_d;
    res_o.sda_out    = sda_d;
    res_o.busy_res   = (phase_d != PH_IDLE);
    res_o.need_byte  = (phase_d == PH_WAITB);
    res_o.read_valid = rv;
    res_o.read_data  = rd;
    res_o.last_byte  = lb;
    res_o.done_res   = dn;
    res_o.nack_error = er;
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      stage_q   <= ST_ADDR_W;
      tick_q    <= 8'd0;
      bit_q     <= 4'd0;
      shift_q   <= 8'd0;
      left_q    <= 8'd0;
      target_q  <= 7'd0;
      regaddr_q <= 8'd0;
      is_read_q <= 1'b0;
      rec_q     <= 16'd0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      failed_q  <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      stage_q   <= stage_d;
      tick_q    <= tick_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      left_q    <= left_d;
      target_q  <= target_d;
      regaddr_q <= regaddr_d;
      is_read_q <= is_read_d;
      rec_q     <= rec_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      failed_q  <= failed_d;
    end
  end

  // A write byte taken while waiting starts its transmission
  a_byte_starts_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && req_i.req_type == REQ_BYTE && phase_q == PH_WAITB
    |=> phase_q == PH_TXBIT && bit_q == 4'd0)
    else $error("write byte did not start transmission");

  // A finished STOP returns the sequencer to idle with lines released
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |=> phase_q == PH_IDLE && scl_q && sda_q)
    else $error("done without returning to idle");

  // Received bytes only come out of the data-read stage
  a_rx_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.read_valid |-> stage_q == ST_DATA_R && phase_q == PH_RXBIT)
    else $error("read byte outside data read");

  // An error is only reported together with done
  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.nack_error |-> res_o.done_res && phase_q == PH_STOP)
    else $error("nack error without stop");

  // Bit counter never reaches a full byte between words
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q < 4'd8)
    else $error("bit counter out of range");

endmodule

@@ hdl/i2cm_out_reg.sv @@
// Output register of the I2C register-transfer master: holds one result word
// until the receiver takes it. Depends on i2cm_pkg.
module i2cm_out_reg import i2cm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  i2cm_res_t data_i,
  input  logic      out_stall_i,
  output logic      full_o,
  output logic      out_valid_o,
  output i2cm_res_t out_data_o
);

  logic      valid_q, valid_d;
  i2cm_res_t data_q;

  // Fill on load, drop once taken
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign full_o      = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ hdl/i2c_register_master.sv @@
// I2C register-transfer master, top level: configuration registers and the
// word handshake around the sequencer. Depends on i2cm_pkg, i2cm_seq, i2cm_out_reg.
//
// Usage: every input word is a one-microsecond tick carrying the sampled SDA
// level, a start command (register write or register read, with slave
// address, register address and byte count) or the next write byte. Every
// accepted word yields exactly one result word with the SCL/SDA drive and the
// status flags (busy, need_byte, read_valid/read_data/last_byte, done, error).
// The result word is loaded into the output register by the clock edge that
// accepts the input word. One word is taken per cycle while in_stall_o is low;
// the sequencer makes one step per word in combinational next-state logic.
// Reset: sequencer idle, both lines released, recovery limit 500 and ACK
// high time 10 ticks. Configuration is written through cfg_we_i/cfg_index_i
// and cfg_data_i; the user must do so only while the block is idle (not enforced).
// Stall: while out_stall_i holds a full output register, in_stall_o is
// raised and the result word holds; as soon as the word is taken, or in the
// same cycle it is taken, a new input word is accepted.
module i2c_register_master import i2cm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2cm_req_t           in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output i2cm_res_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic        full;
  logic        step;
  i2cm_res_t   res;
  logic [15:0] recovery_limit_q;
  logic [7:0]  ack_high_ticks_q;

  // Take a word whenever the output register can accept the result
  assign in_stall_o = full;
  assign step       = in_valid_i && !full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recovery_limit_q <= RESET_RECOVERY;
      ack_high_ticks_q <= RESET_ACK_HIGH;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RECOVERY_LIMIT: recovery_limit_q <= cfg_data_i[15:0];
        CFG_ACK_HIGH_TICKS: ack_high_ticks_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  i2cm_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .req_i            (in_data_i),
    .recovery_limit_i (recovery_limit_q),
    .ack_high_ticks_i (ack_high_ticks_q),
    .res_o            (res)
  );

  i2cm_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .data_i      (res),
    .out_stall_i (out_stall_i),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
